@@ rtl/core/tfa_pkg.sv @@
// shared types and constants for the thermistor frame aggregator
package tfa_pkg;

  localparam int PACK_COUNT_DEF  = 6;
  localparam int SENSORS_PER_PACK = 12;
  localparam int HALF_SIZE        = 6;
  localparam int MAX_PACKS        = 15;
  localparam int MAX_SENSORS      = MAX_PACKS * SENSORS_PER_PACK;
  localparam int IDX_W            = $clog2(MAX_SENSORS + 1);

  localparam logic [15:0] STALE_RESET   = 16'd2000;
  localparam logic [7:0]  MODULE_RESET  = 8'd0;
  localparam logic [7:0]  CK_SEED       = 8'h41;   // 0x39 plus 8
  localparam logic [7:0]  GEN_TAIL      = 8'h80;
  localparam logic [3:0]  MIN_LENGTH    = 4'd6;

  localparam logic [1:0]  MODE_RX     = 2'd0;
  localparam logic [1:0]  MODE_LOCAL  = 2'd1;
  localparam logic [1:0]  MODE_REPORT = 2'd2;

  localparam logic [0:0]  CFG_STALE  = 1'd0;
  localparam logic [0:0]  CFG_MODULE = 1'd1;
  localparam int          CFG_IDX_W  = 1;

  localparam logic        KIND_SUMMARY = 1'b0;
  localparam logic        KIND_GENERAL = 1'b1;

  typedef struct packed {
    logic [1:0]        mode;
    logic [10:0]       frame_id;
    logic              frame_extended;
    logic [3:0]        frame_length;
    logic signed [7:0] temp_a;
    logic signed [7:0] temp_b;
    logic signed [7:0] temp_c;
    logic signed [7:0] temp_d;
    logic signed [7:0] temp_e;
    logic signed [7:0] temp_f;
    logic [31:0]       now_ms;
  } in_beat_t;

  typedef struct packed {
    logic       frame_kind;
    logic [7:0] byte_0;
    logic [7:0] byte_1;
    logic [7:0] byte_2;
    logic [7:0] byte_3;
    logic [7:0] byte_4;
    logic [7:0] byte_5;
    logic [7:0] byte_6;
    logic [7:0] byte_7;
    logic       last;
  } out_beat_t;

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_REPORT
  } cmd_kind_t;

  // classified command handed from front to back
  typedef struct packed {
    cmd_kind_t        kind;
    logic [3:0]       pack;     // 1-based
    logic             upper;    // second half
    logic [6*8-1:0]   temps;
    logic [31:0]      now_ms;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRITE,
    ST_STALE,
    ST_SCAN,
    ST_DIV,
    ST_ROT,
    ST_SUMMARY,
    ST_GENERAL
  } back_state_t;

endpackage

@@ rtl/core/tfa_front.sv @@
// front end: checks and classifies incoming beats into commands
module tfa_front #(
  parameter int PACK_COUNT = tfa_pkg::PACK_COUNT_DEF
) (
  input  logic             in_start,
  input  tfa_pkg::in_beat_t in_data,
  output logic             in_take,
  output logic             push,
  output tfa_pkg::cmd_t    cmd
);

  logic [3:0] pack;
  logic [3:0] half;
  logic       half_ok;
  logic       keep;

  assign pack    = in_data.frame_id[7:4];
  assign half    = in_data.frame_id[3:0];
  assign half_ok = (half == 4'd1) || (half == 4'd2);
  assign in_take = in_start;

  always_comb begin
    keep = 1'b0;
    cmd.kind = tfa_pkg::CMD_WRITE;
    cmd.pack = pack;
    case (in_data.mode)
      tfa_pkg::MODE_RX: begin
        keep = !in_data.frame_extended && (in_data.frame_length >= tfa_pkg::MIN_LENGTH)
               && (pack >= 4'd2) && ({28'd0, pack} <= PACK_COUNT) && half_ok;
      end
      tfa_pkg::MODE_LOCAL: begin
        keep = half_ok;
        cmd.pack = 4'd1;
      end
      tfa_pkg::MODE_REPORT: begin
        keep = 1'b1;
        cmd.kind = tfa_pkg::CMD_REPORT;
      end
      default: keep = 1'b0;
    endcase
    cmd.upper  = (half == 4'd2);
    cmd.temps  = {in_data.temp_f, in_data.temp_e, in_data.temp_d,
                  in_data.temp_c, in_data.temp_b, in_data.temp_a};
    cmd.now_ms = in_data.now_ms;
  end

  assign push = in_start && keep;

endmodule

@@ rtl/core/tfa_queue.sv @@
// two-entry command queue between front and back
module tfa_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tfa_pkg::cmd_t push_cmd,
  input  logic          pop,
  output logic          not_empty,
  output logic          full,
  output tfa_pkg::cmd_t head
);

  tfa_pkg::cmd_t slot_r [2];
  logic          wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]    cnt_r, cnt_nxt;

  assign not_empty = (cnt_r != 2'd0);
  assign full      = (cnt_r == 2'd2);
  assign head      = slot_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r ^ push;
    rp_nxt  = rp_r ^ pop;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wp_r] <= push_cmd;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push || pop) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !not_empty |-> !pop) else $error("queue underflow");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("queue count out of range");

endmodule

@@ rtl/core/tfa_back.sv @@
// back end: table memories, staleness sweep, statistics, divider and frames
module tfa_back #(
  parameter int PACK_COUNT = tfa_pkg::PACK_COUNT_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cmd_valid,
  input  tfa_pkg::cmd_t    cmd,
  output logic             cmd_pop,
  output logic             active,
  input  logic [15:0]      stale_limit,
  input  logic [7:0]       module_number,
  output logic             out_strobe,
  output tfa_pkg::out_beat_t out_data
);

  localparam int TOTAL = PACK_COUNT * tfa_pkg::SENSORS_PER_PACK;
  localparam int IW    = $clog2(TOTAL + 1);
  localparam int AW    = $clog2(TOTAL);
  localparam int SUM_W = 16;
  localparam int DIV_W = 17;

  // storage: temperature and time in memories, valid bits in flops
  logic signed [7:0] temp_mem [TOTAL];
  logic [31:0]       time_mem [TOTAL];
  logic [TOTAL-1:0]  valid_r, valid_nxt;

  tfa_pkg::back_state_t st_r, st_nxt;
  tfa_pkg::cmd_t        cur_r, cur_nxt;
  logic [IW-1:0]        i_r, i_nxt;
  logic [AW-1:0]        ptr_r, ptr_nxt;

  logic signed [7:0]    low_r, low_nxt, high_r, high_nxt;
  logic [7:0]           low_id_r, low_id_nxt, high_id_r, high_id_nxt;
  logic [IW-1:0]        count_r, count_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic [DIV_W-1:0]     rem_r, rem_nxt, quo_r, quo_nxt;
  logic [4:0]           dstep_r, dstep_nxt;
  logic                 neg_r, neg_nxt;
  logic [AW-1:0]        sel_r, sel_nxt;
  logic                 found_r, found_nxt;
  logic signed [7:0]    sel_temp_r;

  // read port, one registered read per cycle
  logic [AW-1:0]        rd_addr;
  logic signed [7:0]    rd_temp_r;
  logic [31:0]          rd_time_r;
  logic                 rd_ok_r, rd_ok_nxt;
  logic [AW-1:0]        rd_idx_r;

  // write port
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic signed [7:0]    wr_temp;

  logic                 out_strobe_r, out_strobe_nxt;
  tfa_pkg::out_beat_t   out_r, out_nxt;

  logic [IW-1:0]        base;
  logic [IW-1:0]        widx;
  logic [IW-1:0]        i_inc;
  logic [AW-1:0]        ptr_inc;
  logic [DIV_W-1:0]     dividend;
  logic [DIV_W-1:0]     divisor;
  logic [DIV_W-1:0]     numer;
  logic [DIV_W:0]       trial;
  logic [7:0]           avg8;
  logic [7:0]           ck;
  logic [2:0]           slot;

  assign slot    = i_r[2:0];
  assign base    = (IW'(cur_r.pack) - IW'(1)) * IW'(tfa_pkg::SENSORS_PER_PACK)
                   + (cur_r.upper ? IW'(tfa_pkg::HALF_SIZE) : IW'(0));
  assign widx    = base + IW'(slot);
  assign i_inc   = i_r + IW'(1);
  assign ptr_inc = (ptr_r == AW'(TOTAL - 1)) ? AW'(0) : ptr_r + AW'(1);
  assign divisor = DIV_W'({count_r, 1'b0});
  assign dividend = (neg_r ? DIV_W'(-sum_r) : DIV_W'(sum_r));
  // 2|sum| + count, divided by 2*count gives the rounded magnitude
  assign numer   = {dividend[DIV_W-2:0], 1'b0} + DIV_W'(count_r);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      temp_mem[wr_addr] <= wr_temp;
      time_mem[wr_addr] <= cur_r.now_ms;
    end
  end

  always_ff @(posedge clk) begin
    rd_temp_r <= temp_mem[rd_addr];
    rd_time_r <= time_mem[rd_addr];
    rd_idx_r  <= rd_addr;
  end

  always_comb begin
    st_nxt      = st_r;
    cur_nxt     = cur_r;
    i_nxt       = i_r;
    ptr_nxt     = ptr_r;
    valid_nxt   = valid_r;
    low_nxt     = low_r;
    high_nxt    = high_r;
    low_id_nxt  = low_id_r;
    high_id_nxt = high_id_r;
    count_nxt   = count_r;
    sum_nxt     = sum_r;
    rem_nxt     = rem_r;
    quo_nxt     = quo_r;
    dstep_nxt   = dstep_r;
    neg_nxt     = neg_r;
    sel_nxt     = sel_r;
    found_nxt   = found_r;
    rd_ok_nxt   = 1'b0;
    rd_addr     = AW'(0);
    wr_en       = 1'b0;
    wr_addr     = AW'(widx);
    wr_temp     = cur_r.temps[slot*8 +: 8];
    cmd_pop     = 1'b0;
    out_strobe_nxt = 1'b0;
    out_nxt     = out_r;
    trial       = '0;
    avg8        = 8'd0;
    ck          = 8'd0;

    case (st_r)
      tfa_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          cur_nxt = cmd;
          i_nxt   = '0;
          if (cmd.kind == tfa_pkg::CMD_REPORT) begin
            st_nxt = tfa_pkg::ST_STALE;
          end else begin
            st_nxt = tfa_pkg::ST_WRITE;
          end
        end
      end
      tfa_pkg::ST_WRITE: begin
        if (widx < IW'(TOTAL)) begin
          wr_en = 1'b1;
          valid_nxt[AW'(widx)] = 1'b1;
        end
        i_nxt = i_inc;
        if (slot == 3'(tfa_pkg::HALF_SIZE - 1)) st_nxt = tfa_pkg::ST_IDLE;
      end
      // staleness: issue reads, check each one in the next cycle
      tfa_pkg::ST_STALE: begin
        if (i_r < IW'(TOTAL)) begin
          rd_addr   = AW'(i_r);
          rd_ok_nxt = 1'b1;
          i_nxt     = i_inc;
        end
        if (rd_ok_r && (cur_r.now_ms - rd_time_r) > {16'd0, stale_limit}) begin
          valid_nxt[rd_idx_r] = 1'b0;
        end
        if (i_r == IW'(TOTAL) && !rd_ok_r) begin
          i_nxt     = '0;
          count_nxt = '0;
          sum_nxt   = '0;
          st_nxt    = tfa_pkg::ST_SCAN;
        end
      end
      tfa_pkg::ST_SCAN: begin
        if (i_r < IW'(TOTAL)) begin
          rd_addr   = AW'(i_r);
          rd_ok_nxt = 1'b1;
          i_nxt     = i_inc;
        end
        if (rd_ok_r && valid_r[rd_idx_r]) begin
          if (count_r == '0 || rd_temp_r < low_r) begin
            low_nxt = rd_temp_r;
            low_id_nxt = 8'(rd_idx_r);
          end
          if (count_r == '0 || rd_temp_r > high_r) begin
            high_nxt = rd_temp_r;
            high_id_nxt = 8'(rd_idx_r);
          end
          sum_nxt   = sum_r + SUM_W'(rd_temp_r);
          count_nxt = count_r + IW'(1);
        end
        if (i_r == IW'(TOTAL) && !rd_ok_r) begin
          if (count_r == '0) begin
            st_nxt = tfa_pkg::ST_IDLE;
          end else begin
            neg_nxt   = sum_r[SUM_W-1];
            rem_nxt   = '0;
            quo_nxt   = '0;
            dstep_nxt = '0;
            st_nxt    = tfa_pkg::ST_DIV;
          end
        end
      end
      // restoring divide of (2|sum| + count) by 2*count, one bit a cycle
      tfa_pkg::ST_DIV: begin
        trial = {rem_r, numer[5'(DIV_W - 1) - dstep_r]};
        if (trial >= {1'b0, divisor}) begin
          rem_nxt = DIV_W'(trial - {1'b0, divisor});
          quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
        end else begin
          rem_nxt = trial[DIV_W-1:0];
          quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
        end
        dstep_nxt = dstep_r + 5'd1;
        if (dstep_r == 5'(DIV_W - 1)) begin
          found_nxt = 1'b0;
          i_nxt     = '0;
          st_nxt    = tfa_pkg::ST_ROT;
        end
      end
      // round-robin pick from the pointer
      tfa_pkg::ST_ROT: begin
        if (valid_r[ptr_r]) begin
          sel_nxt   = ptr_r;
          found_nxt = 1'b1;
          ptr_nxt   = ptr_inc;
          rd_addr   = ptr_r;
          st_nxt    = tfa_pkg::ST_SUMMARY;
        end else begin
          ptr_nxt = ptr_inc;
          i_nxt   = i_inc;
          if (i_inc == IW'(TOTAL)) st_nxt = tfa_pkg::ST_SUMMARY;
        end
      end
      tfa_pkg::ST_SUMMARY: begin
        avg8 = neg_r ? 8'(-quo_r) : quo_r[7:0];
        ck = tfa_pkg::CK_SEED + module_number + low_r + high_r + avg8
             + 8'(count_r) + high_id_r + low_id_r;
        out_strobe_nxt     = 1'b1;
        out_nxt.frame_kind = tfa_pkg::KIND_SUMMARY;
        out_nxt.byte_0     = module_number;
        out_nxt.byte_1     = low_r;
        out_nxt.byte_2     = high_r;
        out_nxt.byte_3     = avg8;
        out_nxt.byte_4     = 8'(count_r);
        out_nxt.byte_5     = high_id_r;
        out_nxt.byte_6     = low_id_r;
        out_nxt.byte_7     = ck;
        out_nxt.last       = !found_r;
        st_nxt = found_r ? tfa_pkg::ST_GENERAL : tfa_pkg::ST_IDLE;
      end
      tfa_pkg::ST_GENERAL: begin
        out_strobe_nxt     = 1'b1;
        out_nxt.frame_kind = tfa_pkg::KIND_GENERAL;
        out_nxt.byte_0     = 8'(sel_r);
        out_nxt.byte_1     = sel_temp_r;
        out_nxt.byte_2     = 8'(sel_r);
        out_nxt.byte_3     = low_r;
        out_nxt.byte_4     = high_r;
        out_nxt.byte_5     = high_id_r;
        out_nxt.byte_6     = low_id_r;
        out_nxt.byte_7     = tfa_pkg::GEN_TAIL;
        out_nxt.last       = 1'b1;
        st_nxt = tfa_pkg::ST_IDLE;
      end
      default: st_nxt = tfa_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (st_r == tfa_pkg::ST_SUMMARY) sel_temp_r <= rd_temp_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= tfa_pkg::ST_IDLE;
      valid_r      <= '0;
      ptr_r        <= '0;
      rd_ok_r      <= 1'b0;
      out_strobe_r <= 1'b0;
      i_r          <= '0;
      count_r      <= '0;
      found_r      <= 1'b0;
    end else begin
      st_r         <= st_nxt;
      valid_r      <= valid_nxt;
      ptr_r        <= ptr_nxt;
      rd_ok_r      <= rd_ok_nxt;
      out_strobe_r <= out_strobe_nxt;
      i_r          <= i_nxt;
      count_r      <= count_nxt;
      found_r      <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r     <= cur_nxt;
    low_r     <= low_nxt;
    high_r    <= high_nxt;
    low_id_r  <= low_id_nxt;
    high_id_r <= high_id_nxt;
    sum_r     <= sum_nxt;
    rem_r     <= rem_nxt;
    quo_r     <= quo_nxt;
    dstep_r   <= dstep_nxt;
    neg_r     <= neg_nxt;
    sel_r     <= sel_nxt;
    out_r     <= out_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_r;
  assign active     = (st_r != tfa_pkg::ST_IDLE) || out_strobe_r;

  a_general_after_summary: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && out_r.frame_kind == tfa_pkg::KIND_GENERAL)
      |-> $past(out_strobe_r) && !$past(out_r.last))
    else $error("general frame without a summary before it");
  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> st_r == tfa_pkg::ST_IDLE) else $error("pop while busy");
  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    ptr_r <= AW'(TOTAL - 1)) else $error("pointer out of range");

endmodule

@@ rtl/core/thermistor_frame_aggregator.sv @@
// top level of the thermistor frame aggregator
//
//  channel  | handshake               | payload
//  ---------+-------------------------+---------------------------
//  in_      | start / busy            | in_data  (tfa_pkg::in_beat_t)
//  out_     | out_strobe, one cycle   | out_data (tfa_pkg::out_beat_t)
//  cfg_     | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// a table write holds the back end for the queue pop and six memory writes,
// one per cycle
// a report holds it for the pop, a stale sweep and a statistics scan over the
// single read port, a 17-step divider for the average, a round-robin search of
// the valid bits one per cycle, then the summary and general frames; with no
// valid entry it ends after the scan
// busy is high while the two-entry command queue is full
// rst_n is synchronous; table valid bits and the pointer clear at once
// the receiver cannot stall: each result beat shows for one cycle
module thermistor_frame_aggregator #(
  parameter int PACK_COUNT = tfa_pkg::PACK_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  tfa_pkg::in_beat_t  in_data,
  output logic               out_strobe,
  output tfa_pkg::out_beat_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  // configuration registers
  logic [15:0] stale_r;
  logic [7:0]  module_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stale_r  <= tfa_pkg::STALE_RESET;
      module_r <= tfa_pkg::MODULE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == 8'(tfa_pkg::CFG_STALE)) stale_r <= cfg_data;
      else if (cfg_index == 8'(tfa_pkg::CFG_MODULE)) module_r <= cfg_data[7:0];
    end
  end

  // front to queue
  logic          fe_take, fe_push;
  tfa_pkg::cmd_t fe_cmd;
  logic          q_ne, q_full, q_pop, be_active;
  tfa_pkg::cmd_t q_head;

  assign busy = q_full;

  tfa_front #(.PACK_COUNT(PACK_COUNT)) u_front (
    .in_start(start && !busy),
    .in_data (in_data),
    .in_take (fe_take),
    .push    (fe_push),
    .cmd     (fe_cmd)
  );

  tfa_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (fe_push && fe_take),
    .push_cmd (fe_cmd),
    .pop      (q_pop),
    .not_empty(q_ne),
    .full     (q_full),
    .head     (q_head)
  );

  tfa_back #(.PACK_COUNT(PACK_COUNT)) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_valid    (q_ne),
    .cmd          (q_head),
    .cmd_pop      (q_pop),
    .active       (be_active),
    .stale_limit  (stale_r),
    .module_number(module_r),
    .out_strobe   (out_strobe),
    .out_data     (out_data)
  );

  a_no_push_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !(fe_push && fe_take)) else $error("push while queue full");
  a_strobe_needs_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(be_active)) else $error("result with idle back end");
  a_cfg_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !(cfg_valid && cfg_index <= 8'(tfa_pkg::CFG_MODULE)) |=> $stable(stale_r))
    else $error("stale limit changed without a write");

endmodule

@@ tb/thermistor_frame_aggregator_tb.sv @@
// testbench for the thermistor frame aggregator: table predictor, scoreboard and stimulus
module thermistor_frame_aggregator_tb;

  localparam int          PACKS        = tfa_pkg::PACK_COUNT_DEF;
  localparam int          PER_PACK     = tfa_pkg::SENSORS_PER_PACK;
  localparam int          HALF_N       = tfa_pkg::HALF_SIZE;
  localparam int          SENSOR_TOTAL = PACKS * PER_PACK;
  localparam logic [1:0]  MODE_NONE    = 2'd3;     // unused mode, no effect
  localparam logic [7:0]  CFG_UNKNOWN  = 8'd5;     // index beyond the register list
  localparam int          DRAIN_CYCLES = 700;      // well over one full report
  localparam int          LOG_LIMIT    = 10;

  // predicts the frames of the aggregator and checks them in order
  class frame_scoreboard;
    logic signed [7:0]   temps[SENSOR_TOTAL];
    bit                  live[SENSOR_TOTAL];
    logic [31:0]         stamp[SENSOR_TOTAL];
    int                  rr_ptr;
    logic [15:0]         stale_ms;
    logic [7:0]          module_id;
    tfa_pkg::out_beat_t  pending[$];
    int                  errors;

    function new();
      foreach (temps[i]) begin
        temps[i] = '0;
        live[i]  = 0;
        stamp[i] = '0;
      end
      rr_ptr    = 0;
      stale_ms  = tfa_pkg::STALE_RESET;
      module_id = tfa_pkg::MODULE_RESET;
      errors    = 0;
    endfunction

    function void note_config(logic [7:0] idx, logic [15:0] val);
      if (idx == 8'(tfa_pkg::CFG_STALE)) stale_ms = val;
      else if (idx == 8'(tfa_pkg::CFG_MODULE)) module_id = val[7:0];
    endfunction

    function void store_half(int pack, logic [3:0] half, tfa_pkg::in_beat_t b);
      int base;
      logic signed [7:0] six[HALF_N];
      base = (pack - 1) * PER_PACK + (half == 4'd1 ? 0 : HALF_N);
      six = '{b.temp_a, b.temp_b, b.temp_c, b.temp_d, b.temp_e, b.temp_f};
      for (int i = 0; i < HALF_N; i++) begin
        temps[base + i] = six[i];
        live[base + i]  = 1;
        stamp[base + i] = b.now_ms;
      end
    endfunction

    // one accepted input beat: update the table, queue any frames it causes
    function void note_input(tfa_pkg::in_beat_t b);
      logic [3:0] pack, half;
      int cnt, sum, avg, lo, hi, lo_at, hi_at, sel;
      bit found;
      logic [7:0] ck;
      tfa_pkg::out_beat_t f;
      pack = b.frame_id[7:4];
      half = b.frame_id[3:0];
      case (b.mode)
        tfa_pkg::MODE_RX: begin
          if (!b.frame_extended && b.frame_length >= tfa_pkg::MIN_LENGTH && pack >= 2 &&
              pack <= PACKS && (half == 4'd1 || half == 4'd2))
            store_half(pack, half, b);
        end
        tfa_pkg::MODE_LOCAL: begin
          if (half == 4'd1 || half == 4'd2) store_half(1, half, b);
        end
        tfa_pkg::MODE_REPORT: begin
          // stale sweep first, then stats over what survives
          for (int i = 0; i < SENSOR_TOTAL; i++)
            if (live[i] && (b.now_ms - stamp[i]) > {16'd0, stale_ms}) live[i] = 0;
          cnt = 0; sum = 0; lo = 0; hi = 0; lo_at = 0; hi_at = 0;
          for (int i = 0; i < SENSOR_TOTAL; i++) begin
            if (!live[i]) continue;
            if (cnt == 0) begin
              lo = temps[i]; hi = temps[i]; lo_at = i; hi_at = i;
            end else begin
              if (temps[i] < lo) begin lo = temps[i]; lo_at = i; end
              if (temps[i] > hi) begin hi = temps[i]; hi_at = i; end
            end
            sum += temps[i];
            cnt++;
          end
          if (cnt == 0) return;
          // round to nearest, halves away from zero
          if (sum >= 0) avg = (2 * sum + cnt) / (2 * cnt);
          else avg = -((2 * (-sum) + cnt) / (2 * cnt));
          found = 0; sel = 0;
          for (int i = 0; i < SENSOR_TOTAL; i++) begin
            int at;
            at = rr_ptr;
            rr_ptr = (rr_ptr + 1 >= SENSOR_TOTAL) ? 0 : rr_ptr + 1;
            if (live[at]) begin
              sel = at; found = 1;
              break;
            end
          end
          f.frame_kind = tfa_pkg::KIND_SUMMARY;
          f.byte_0 = module_id;
          f.byte_1 = lo[7:0];
          f.byte_2 = hi[7:0];
          f.byte_3 = avg[7:0];
          f.byte_4 = cnt[7:0];
          f.byte_5 = hi_at[7:0];
          f.byte_6 = lo_at[7:0];
          ck = tfa_pkg::CK_SEED + f.byte_0 + f.byte_1 + f.byte_2 + f.byte_3 + f.byte_4 +
               f.byte_5 + f.byte_6;
          f.byte_7 = ck;
          f.last = !found;
          pending.push_back(f);
          if (!found) return;
          f.frame_kind = tfa_pkg::KIND_GENERAL;
          f.byte_0 = sel[7:0];
          f.byte_1 = temps[sel];
          f.byte_2 = sel[7:0];
          f.byte_3 = lo[7:0];
          f.byte_4 = hi[7:0];
          f.byte_5 = hi_at[7:0];
          f.byte_6 = lo_at[7:0];
          f.byte_7 = tfa_pkg::GEN_TAIL;
          f.last = 1'b1;
          pending.push_back(f);
        end
        default: ;
      endcase
    endfunction

    function void flag(string what, tfa_pkg::out_beat_t want, tfa_pkg::out_beat_t got);
      errors++;
      if (errors <= LOG_LIMIT)
        $display("frame error (%s): expected %h got %h", what, want, got);
    endfunction

    function void check_frame(tfa_pkg::out_beat_t got);
      tfa_pkg::out_beat_t want;
      if (pending.size() == 0) begin
        flag("no frame pending", '0, got);
        return;
      end
      want = pending.pop_front();
      if (got.frame_kind !== want.frame_kind) flag("frame_kind", want, got);
      if (got.byte_0 !== want.byte_0) flag("byte_0", want, got);
      if (got.byte_1 !== want.byte_1) flag("byte_1", want, got);
      if (got.byte_2 !== want.byte_2) flag("byte_2", want, got);
      if (got.byte_3 !== want.byte_3) flag("byte_3", want, got);
      if (got.byte_4 !== want.byte_4) flag("byte_4", want, got);
      if (got.byte_5 !== want.byte_5) flag("byte_5", want, got);
      if (got.byte_6 !== want.byte_6) flag("byte_6", want, got);
      if (got.byte_7 !== want.byte_7) flag("byte_7", want, got);
      if (got.last !== want.last) flag("last", want, got);
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  tfa_pkg::in_beat_t  in_data;
  logic               out_strobe;
  tfa_pkg::out_beat_t out_data;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [7:0]         cfg_index;
  logic [15:0]        cfg_data;

  frame_scoreboard sb = new();
  logic [31:0] clock_ms;     // running millisecond time for the stimulus
  int          beat_no;
  bit          no_gaps;      // long stretch without sender idling

  thermistor_frame_aggregator DUT (
    .clk(clk), .rst_n(rst_n),
    .start(start), .busy(busy), .in_data(in_data),
    .out_strobe(out_strobe), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // safety net: generous bound over the slowest legal run
  initial begin
    #60000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // result beats cannot be held off, so every strobe is checked at once
  always @(posedge clk) begin
    if (rst_n && out_strobe) sb.check_frame(out_data);
  end

  // drive one beat from a falling edge; it holds until accepted, then the
  // sender may idle before the next beat unless no_gaps is set
  task automatic send_beat(tfa_pkg::in_beat_t b);
    start   = 1'b1;
    in_data = b;
    do @(posedge clk); while (busy);
    sb.note_input(b);
    beat_no++;
    @(negedge clk);
    start = 1'b0;
    while (!no_gaps && $urandom_range(0, 99) < 18) @(negedge clk);
  endtask

  // sender pause: wait for every pending frame, then let any trailing work finish
  task automatic drain();
    int guard;
    guard = 0;
    while (sb.pending.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    sb.note_config(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic tfa_pkg::in_beat_t make_beat(logic [1:0] m, logic [10:0] id,
                                                  logic ext, logic [3:0] len,
                                                  logic [31:0] now);
    tfa_pkg::in_beat_t b;
    b.mode = m; b.frame_id = id; b.frame_extended = ext; b.frame_length = len;
    b.temp_a = 8'($urandom); b.temp_b = 8'($urandom); b.temp_c = 8'($urandom);
    b.temp_d = 8'($urandom); b.temp_e = 8'($urandom); b.temp_f = 8'($urandom);
    b.now_ms = now;
    return b;
  endfunction

  // mostly well-formed frames and reports, with some junk mixed in
  function automatic tfa_pkg::in_beat_t random_beat();
    tfa_pkg::in_beat_t b;
    int pick;
    logic [10:0] id;
    pick = $urandom_range(0, 99);
    // time mostly creeps forward, sometimes jumps far or anywhere
    if ($urandom_range(0, 49) == 0) clock_ms = $urandom;
    else if ($urandom_range(0, 19) == 0) clock_ms += $urandom_range(0, 70000);
    else clock_ms += $urandom_range(0, 40);
    id = {3'($urandom), 4'($urandom_range(2, PACKS)), 4'($urandom_range(1, 2))};
    if (pick < 50) begin
      b = make_beat(tfa_pkg::MODE_RX, id, 1'b0, 4'($urandom_range(6, 15)), clock_ms);
    end else if (pick < 62) begin
      b = make_beat(tfa_pkg::MODE_LOCAL, {7'($urandom), 4'($urandom_range(1, 2))},
                    1'($urandom), 4'($urandom), clock_ms);
    end else if (pick < 86) begin
      b = make_beat(tfa_pkg::MODE_REPORT, 11'($urandom), 1'($urandom), 4'($urandom),
                    clock_ms);
    end else if (pick < 98) begin
      b = make_beat(2'($urandom_range(0, 1)), 11'($urandom), 1'($urandom), 4'($urandom),
                    clock_ms);
    end else begin
      b = make_beat(MODE_NONE, 11'($urandom), 1'($urandom), 4'($urandom), clock_ms);
    end
    // narrow temperatures now and then so ties happen
    if ($urandom_range(0, 3) == 0) begin
      b.temp_a = 8'($urandom_range(0, 3)); b.temp_b = 8'($urandom_range(0, 3));
      b.temp_c = 8'($urandom_range(0, 3)); b.temp_d = 8'($urandom_range(0, 3));
      b.temp_e = 8'($urandom_range(0, 3)); b.temp_f = 8'($urandom_range(0, 3));
    end
    return b;
  endfunction

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) begin
      no_gaps = (i >= 100 && i < 250);
      send_beat(random_beat());
    end
    no_gaps = 0;
  endtask

  initial begin
    tfa_pkg::in_beat_t b;
    int guard;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    clock_ms = '0;
    beat_no = 0;
    no_gaps = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty table: a report gives nothing
    send_beat(make_beat(tfa_pkg::MODE_REPORT, '0, 1'b0, '0, 32'd0));
    // local halves, the first with extreme temperatures
    b = make_beat(tfa_pkg::MODE_LOCAL, 11'h001, 1'b1, 4'd0, 32'd10);
    b.temp_a = 8'sd127; b.temp_b = -8'sd128; b.temp_c = 8'sd0;
    b.temp_d = -8'sd1; b.temp_e = 8'sd1; b.temp_f = -8'sd128;
    send_beat(b);
    send_beat(make_beat(tfa_pkg::MODE_LOCAL, 11'h7F2, 1'b0, 4'd15, 32'd10));
    // accepted remote half with upper id bits set and an oversized length
    send_beat(make_beat(tfa_pkg::MODE_RX, 11'h762, 1'b0, 4'd15, 32'd20));
    send_beat(make_beat(tfa_pkg::MODE_RX, 11'h021, 1'b0, 4'd6, 32'd20));
    // rejected frames: extended, short, bad pack, bad half, own pack
    send_beat(make_beat(tfa_pkg::MODE_RX, 11'h031, 1'b1, 4'd8, 32'd20));
    send_beat(make_beat(tfa_pkg::MODE_RX, 11'h031, 1'b0, 4'd5, 32'd20));
    send_beat(make_beat(tfa_pkg::MODE_RX, 11'h001, 1'b0, 4'd8, 32'd20));
    send_beat(make_beat(tfa_pkg::MODE_RX, 11'h071, 1'b0, 4'd8, 32'd20));
    send_beat(make_beat(tfa_pkg::MODE_RX, 11'h0F2, 1'b0, 4'd8, 32'd20));
    send_beat(make_beat(tfa_pkg::MODE_RX, 11'h030, 1'b0, 4'd8, 32'd20));
    send_beat(make_beat(tfa_pkg::MODE_RX, 11'h033, 1'b0, 4'd8, 32'd20));
    send_beat(make_beat(tfa_pkg::MODE_RX, 11'h011, 1'b0, 4'd8, 32'd20));
    send_beat(make_beat(tfa_pkg::MODE_LOCAL, 11'h00F, 1'b0, 4'd8, 32'd20));
    send_beat(make_beat(MODE_NONE, 11'h7FF, 1'b1, 4'd15, 32'd20));
    send_beat(make_beat(tfa_pkg::MODE_REPORT, '0, 1'b0, '0, 32'd25));
    // all-equal half for tie handling
    b = make_beat(tfa_pkg::MODE_RX, 11'h041, 1'b0, 4'd8, 32'd30);
    b.temp_a = -8'sd7; b.temp_b = -8'sd7; b.temp_c = -8'sd7;
    b.temp_d = -8'sd7; b.temp_e = -8'sd7; b.temp_f = -8'sd7;
    send_beat(b);
    send_beat(make_beat(tfa_pkg::MODE_REPORT, '0, 1'b0, '0, 32'd30));
    // age exactly at the limit stays, one past it drops
    send_beat(make_beat(tfa_pkg::MODE_REPORT, '0, 1'b0, '0, 32'd2020));
    send_beat(make_beat(tfa_pkg::MODE_REPORT, '0, 1'b0, '0, 32'd2021));
    // time wrap around the top of the counter
    send_beat(make_beat(tfa_pkg::MODE_LOCAL, 11'h001, 1'b0, 4'd8, 32'hFFFF_FFFF));
    send_beat(make_beat(tfa_pkg::MODE_REPORT, '0, 1'b0, '0, 32'd5));
    send_beat(make_beat(tfa_pkg::MODE_REPORT, '0, 1'b0, '0, 32'hFFFF_0000));
    clock_ms = 32'hFFFF_FF00;

    // sender pause until every pending frame is out
    drain();
    write_reg(8'(tfa_pkg::CFG_STALE), 16'd0);
    write_reg(8'(tfa_pkg::CFG_MODULE), 16'hFFFF);
    random_phase(300);

    drain();
    write_reg(8'(tfa_pkg::CFG_STALE), 16'hFFFF);
    write_reg(8'(tfa_pkg::CFG_MODULE), 16'h00A5);
    random_phase(300);

    drain();
    write_reg(CFG_UNKNOWN, 16'h1234);
    write_reg(8'(tfa_pkg::CFG_STALE), 16'd300);
    write_reg(8'(tfa_pkg::CFG_MODULE), 16'd0);
    random_phase(300);

    drain();
    write_reg(8'(tfa_pkg::CFG_STALE), tfa_pkg::STALE_RESET);
    write_reg(8'(tfa_pkg::CFG_MODULE), 16'd255);
    random_phase(300);

    // wait out the tail, bounded
    guard = 0;
    while (sb.pending.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/tfa_pkg.sv
rtl/core/tfa_front.sv
rtl/core/tfa_queue.sv
rtl/core/tfa_back.sv
rtl/core/thermistor_frame_aggregator.sv
tb/thermistor_frame_aggregator_tb.sv
